@@ rtl/core/kuf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and constants of the spanning-tree edge filter.
// ----------------------------------------------------------------------------
package kuf_pkg;

    localparam int VTX_W    = 10;
    localparam int WEIGHT_W = 18;
    localparam int RANK_W   = 4;
    localparam int VTX_CAP  = (1 << VTX_W) - 1;

    localparam logic [VTX_W-1:0]  VTX_RESET = VTX_W'(VTX_CAP);
    localparam logic [RANK_W-1:0] RANK_MAX  = '1;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    typedef struct packed {
        logic par_rd;
        logic par_wr;
        logic rank_rd;
        logic rank_wr;
    } t_store_en;

    typedef struct packed {
        logic             accepted;
        logic [VTX_W-1:0] taken_count;
        logic             tree_complete;
        logic             bad_endpoint;
    } t_verdict;

endpackage

@@ rtl/core/kuf_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_store
// Parent and rank memories, each with one write port and one registered read.
// ----------------------------------------------------------------------------
module kuf_store
    import kuf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  t_store_en         i_en,
    input  logic [AW-1:0]     i_par_raddr,
    input  logic [AW-1:0]     i_par_waddr,
    input  logic [AW-1:0]     i_par_wdata,
    input  logic [AW-1:0]     i_rank_raddr,
    input  logic [AW-1:0]     i_rank_waddr,
    input  logic [RANK_W-1:0] i_rank_wdata,
    output logic [AW-1:0]     o_par_rdata,
    output logic [RANK_W-1:0] o_rank_rdata
);

    logic [AW-1:0]     r_parent_mem [DEPTH];
    logic [RANK_W-1:0] r_rank_mem   [DEPTH];
    logic [AW-1:0]     r_par_rdata;
    logic [RANK_W-1:0] r_rank_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en.par_wr) begin
            r_parent_mem[i_par_waddr] <= i_par_wdata;
        end
        if (i_en.par_rd) begin
            r_par_rdata <= r_parent_mem[i_par_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rank_wr) begin
            r_rank_mem[i_rank_waddr] <= i_rank_wdata;
        end
        if (i_en.rank_rd) begin
            r_rank_rdata <= r_rank_mem[i_rank_raddr];
        end
    end

    assign o_par_rdata  = r_par_rdata;
    assign o_rank_rdata = r_rank_rdata;

endmodule

@@ rtl/core/kuf_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuf_seq
// Sequencer that walks, compresses and unites sets with one equality test.
// ----------------------------------------------------------------------------
module kuf_seq
    import kuf_pkg::*;
#(
    parameter int MAX_VERTICES = 1023,
    parameter int AW           = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_operation,
    input  logic [VTX_W-1:0]  i_endpoint_a,
    input  logic [VTX_W-1:0]  i_endpoint_b,
    input  logic [VTX_W-1:0]  i_vertices,
    input  logic              i_slot_free,
    input  logic [AW-1:0]     i_par_rdata,
    input  logic [RANK_W-1:0] i_rank_rdata,
    output logic              o_ready,
    output logic              o_result_valid,
    output t_verdict          o_verdict,
    output t_store_en         o_en,
    output logic [AW-1:0]     o_par_raddr,
    output logic [AW-1:0]     o_par_waddr,
    output logic [AW-1:0]     o_par_wdata,
    output logic [AW-1:0]     o_rank_raddr,
    output logic [AW-1:0]     o_rank_waddr,
    output logic [RANK_W-1:0] o_rank_wdata
);

    localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_VERTICES);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_FIND_A,
        ST_COMP_A,
        ST_FIND_B,
        ST_COMP_B,
        ST_UNITE,
        ST_DONE
    } t_state;

    t_state            r_state,  n_state;
    logic [AW-1:0]     r_idx,    n_idx;
    logic [AW-1:0]     r_cur,    n_cur;
    logic [AW-1:0]     r_va,     n_va;
    logic [AW-1:0]     r_vb,     n_vb;
    logic [AW-1:0]     r_root_a, n_root_a;
    logic [AW-1:0]     r_root_b, n_root_b;
    logic [RANK_W-1:0] r_rank_a, n_rank_a;
    logic [VTX_W-1:0]  r_taken,  n_taken;
    logic              r_report, n_report;
    t_verdict          r_verdict, n_verdict;

    logic          bad;
    logic [AW-1:0] cmp_x;
    logic [AW-1:0] cmp_y;
    logic          cmp_eq;

    function automatic logic complete_at(input logic [VTX_W-1:0] n,
                                         input logic [VTX_W-1:0] taken);
        logic [VTX_W:0] sum;
        sum = {1'b0, taken} + 1'b1;
        return (n != '0) && (sum >= {1'b0, n});
    endfunction

    assign bad = (i_endpoint_a == '0) || (i_endpoint_b == '0) ||
                 (i_endpoint_a > i_vertices) || (i_endpoint_b > i_vertices);

    always_comb begin
        cmp_x = r_cur;
        cmp_y = r_root_a;
        unique case (r_state)
            ST_FIND_A, ST_FIND_B: begin
                cmp_x = i_par_rdata;
                cmp_y = r_cur;
            end
            ST_COMP_B: begin
                cmp_y = r_root_b;
            end
            ST_UNITE: begin
                cmp_x = r_root_a;
                cmp_y = r_root_b;
            end
            default: begin
            end
        endcase
    end

    assign cmp_eq = (cmp_x == cmp_y);

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_cur          = r_cur;
        n_va           = r_va;
        n_vb           = r_vb;
        n_root_a       = r_root_a;
        n_root_b       = r_root_b;
        n_rank_a       = r_rank_a;
        n_taken        = r_taken;
        n_report       = r_report;
        n_verdict      = r_verdict;
        o_en           = '0;
        o_par_raddr    = r_cur;
        o_par_waddr    = r_cur;
        o_par_wdata    = r_root_a;
        o_rank_raddr   = r_cur;
        o_rank_waddr   = r_idx;
        o_rank_wdata   = '0;
        o_result_valid = 1'b0;

        unique case (r_state)
            ST_SWEEP: begin
                o_en.par_wr  = 1'b1;
                o_en.rank_wr = 1'b1;
                o_par_waddr  = r_idx;
                o_par_wdata  = r_idx;
                n_idx        = r_idx + 1'b1;
                if (r_idx == LAST_ENTRY) begin
                    n_state = r_report ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_CLEAR) begin
                        n_idx     = '0;
                        n_taken   = '0;
                        n_report  = 1'b1;
                        n_verdict = '{accepted: 1'b0, taken_count: '0,
                                      tree_complete: complete_at(i_vertices, '0),
                                      bad_endpoint: 1'b0};
                        n_state   = ST_SWEEP;
                    end else if (bad || complete_at(i_vertices, r_taken)) begin
                        n_verdict = '{accepted: 1'b0, taken_count: r_taken,
                                      tree_complete: complete_at(i_vertices, r_taken),
                                      bad_endpoint: bad};
                        n_state   = ST_DONE;
                    end else begin
                        o_en.par_rd = 1'b1;
                        o_par_raddr = AW'(i_endpoint_a);
                        n_cur       = AW'(i_endpoint_a);
                        n_va        = AW'(i_endpoint_a);
                        n_vb        = AW'(i_endpoint_b);
                        n_state     = ST_FIND_A;
                    end
                end
            end
            ST_FIND_A: begin
                o_en.par_rd = 1'b1;
                if (cmp_eq) begin
                    n_root_a     = r_cur;
                    o_en.rank_rd = 1'b1;
                    o_rank_raddr = r_cur;
                    o_par_raddr  = r_va;
                    n_cur        = r_va;
                    n_state      = ST_COMP_A;
                end else begin
                    o_par_raddr = i_par_rdata;
                    n_cur       = i_par_rdata;
                end
            end
            ST_COMP_A: begin
                o_en.par_rd = 1'b1;
                if (cmp_eq) begin
                    o_par_raddr = r_vb;
                    n_cur       = r_vb;
                    n_state     = ST_FIND_B;
                end else begin
                    o_en.par_wr = 1'b1;
                    o_par_wdata = r_root_a;
                    o_par_raddr = i_par_rdata;
                    n_cur       = i_par_rdata;
                end
            end
            ST_FIND_B: begin
                o_en.par_rd = 1'b1;
                n_rank_a    = i_rank_rdata;
                if (cmp_eq) begin
                    n_root_b     = r_cur;
                    o_en.rank_rd = 1'b1;
                    o_rank_raddr = r_cur;
                    o_par_raddr  = r_vb;
                    n_cur        = r_vb;
                    n_state      = ST_COMP_B;
                end else begin
                    o_par_raddr = i_par_rdata;
                    n_cur       = i_par_rdata;
                end
            end
            ST_COMP_B: begin
                if (cmp_eq) begin
                    n_state = ST_UNITE;
                end else begin
                    o_en.par_rd = 1'b1;
                    o_en.par_wr = 1'b1;
                    o_par_wdata = r_root_b;
                    o_par_raddr = i_par_rdata;
                    n_cur       = i_par_rdata;
                end
            end
            ST_UNITE: begin
                if (cmp_eq) begin
                    n_verdict = '{accepted: 1'b0, taken_count: r_taken,
                                  tree_complete: complete_at(i_vertices, r_taken),
                                  bad_endpoint: 1'b0};
                end else begin
                    o_en.par_wr = 1'b1;
                    if (r_rank_a > i_rank_rdata) begin
                        o_par_waddr = r_root_b;
                        o_par_wdata = r_root_a;
                    end else begin
                        o_par_waddr = r_root_a;
                        o_par_wdata = r_root_b;
                        if ((r_rank_a == i_rank_rdata) && (i_rank_rdata != RANK_MAX)) begin
                            o_en.rank_wr = 1'b1;
                            o_rank_waddr = r_root_b;
                            o_rank_wdata = i_rank_rdata + 1'b1;
                        end
                    end
                    n_taken   = r_taken + 1'b1;
                    n_verdict = '{accepted: 1'b1, taken_count: n_taken,
                                  tree_complete: complete_at(i_vertices, n_taken),
                                  bad_endpoint: 1'b0};
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_slot_free) begin
                    o_result_valid = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SWEEP;
            r_idx    <= '0;
            r_taken  <= '0;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_taken  <= n_taken;
            r_report <= n_report;
        end
        r_cur     <= n_cur;
        r_va      <= n_va;
        r_vb      <= n_vb;
        r_root_a  <= n_root_a;
        r_root_b  <= n_root_b;
        r_rank_a  <= n_rank_a;
        r_verdict <= n_verdict;
    end

    assign o_ready   = (r_state == ST_IDLE);
    assign o_verdict = r_verdict;

endmodule

@@ rtl/core/kruskal_union_find_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_union_find_filter
// Spanning-tree edge filter over a disjoint-set store with union by rank
// and path compression; the user must offer edges in weight order, unchecked.
//
//   channel | direction | handshake                  | words
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_ready    | clear or edge items
//   out     | output    | o_out_valid / i_out_ready  | one verdict per item
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | vertex_count writes
//
// An edge's find and compression walks are bound by the single read port of
// the parent memory, walked one link a cycle. A bad endpoint or a complete
// tree skips the walks; a clear rewrites every store entry, one per cycle.
// After reset a clearing pass runs over every entry with o_in_ready low;
// configuration words are taken at all times. A stalled result waits in the
// output register while the next item is already accepted.
// ----------------------------------------------------------------------------
module kruskal_union_find_filter
    import kuf_pkg::*;
#(
    parameter int MAX_VERTICES = 1023
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic [VTX_W-1:0]    i_endpoint_a,
    input  logic [VTX_W-1:0]    i_endpoint_b,
    input  logic [WEIGHT_W-1:0] i_edge_weight,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_accepted,
    output logic [VTX_W-1:0]    o_tree_a,
    output logic [VTX_W-1:0]    o_tree_b,
    output logic [WEIGHT_W-1:0] o_tree_weight,
    output logic [VTX_W-1:0]    o_taken_count,
    output logic                o_tree_complete,
    output logic                o_bad_endpoint,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [VTX_W-1:0]    i_cfg_data
);

    localparam int DEPTH = MAX_VERTICES + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CAP   = (MAX_VERTICES < VTX_CAP) ? MAX_VERTICES : VTX_CAP;
    localparam logic [VTX_W-1:0] N_CAP = VTX_W'(CAP);

    logic [VTX_W-1:0]    r_vertex_count;
    logic [VTX_W-1:0]    vertices;
    logic                in_accept;
    logic                slot_free;
    logic                seq_ready;
    logic                result_valid;
    t_verdict            verdict;
    t_store_en           store_en;
    logic [AW-1:0]       par_raddr;
    logic [AW-1:0]       par_waddr;
    logic [AW-1:0]       par_wdata;
    logic [AW-1:0]       rank_raddr;
    logic [AW-1:0]       rank_waddr;
    logic [RANK_W-1:0]   rank_wdata;
    logic [AW-1:0]       par_rdata;
    logic [RANK_W-1:0]   rank_rdata;

    logic [VTX_W-1:0]    r_echo_a;
    logic [VTX_W-1:0]    r_echo_b;
    logic [WEIGHT_W-1:0] r_echo_w;
    logic                r_out_valid;
    logic                r_accepted;
    logic [VTX_W-1:0]    r_tree_a;
    logic [VTX_W-1:0]    r_tree_b;
    logic [WEIGHT_W-1:0] r_tree_weight;
    logic [VTX_W-1:0]    r_taken_count;
    logic                r_tree_complete;
    logic                r_bad_endpoint;

    assign vertices    = (r_vertex_count > N_CAP) ? N_CAP : r_vertex_count;
    assign o_in_ready  = seq_ready;
    assign in_accept   = i_in_valid && seq_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    kuf_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (in_accept),
        .i_operation    (i_operation),
        .i_endpoint_a   (i_endpoint_a),
        .i_endpoint_b   (i_endpoint_b),
        .i_vertices     (vertices),
        .i_slot_free    (slot_free),
        .i_par_rdata    (par_rdata),
        .i_rank_rdata   (rank_rdata),
        .o_ready        (seq_ready),
        .o_result_valid (result_valid),
        .o_verdict      (verdict),
        .o_en           (store_en),
        .o_par_raddr    (par_raddr),
        .o_par_waddr    (par_waddr),
        .o_par_wdata    (par_wdata),
        .o_rank_raddr   (rank_raddr),
        .o_rank_waddr   (rank_waddr),
        .o_rank_wdata   (rank_wdata)
    );

    kuf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk        (i_clk),
        .i_en         (store_en),
        .i_par_raddr  (par_raddr),
        .i_par_waddr  (par_waddr),
        .i_par_wdata  (par_wdata),
        .i_rank_raddr (rank_raddr),
        .i_rank_waddr (rank_waddr),
        .i_rank_wdata (rank_wdata),
        .o_par_rdata  (par_rdata),
        .o_rank_rdata (rank_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VTX_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vertex_count <= i_cfg_data;
            end
            if (result_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_accept) begin
            r_echo_a <= i_endpoint_a;
            r_echo_b <= i_endpoint_b;
            r_echo_w <= i_edge_weight;
        end
        if (result_valid) begin
            r_accepted      <= verdict.accepted;
            r_tree_a        <= r_echo_a;
            r_tree_b        <= r_echo_b;
            r_tree_weight   <= r_echo_w;
            r_taken_count   <= verdict.taken_count;
            r_tree_complete <= verdict.tree_complete;
            r_bad_endpoint  <= verdict.bad_endpoint;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_tree_a        = r_tree_a;
    assign o_tree_b        = r_tree_b;
    assign o_tree_weight   = r_tree_weight;
    assign o_taken_count   = r_taken_count;
    assign o_tree_complete = r_tree_complete;
    assign o_bad_endpoint  = r_bad_endpoint;

endmodule
